FILE: sv/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SNCP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sncp assertion failed");

// next-cycle implication
`define SNCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sncp assertion failed");

`endif

FILE: sv/sncp_pkg.sv
package sncp_pkg;

    // sizing
    localparam int MAX_SAMPLES  = 256;
    localparam int MAX_SEGMENTS = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 8;

    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int LOG_N     = $clog2(MAX_SAMPLES);
    localparam int SUM_W     = SAMPLE_BITS + LOG_N + 1;
    localparam int ABS_W     = SUM_W - 1;
    localparam int SQ_W      = 2 * (SAMPLE_BITS - 1) + LOG_N + 1;
    localparam int PRE_W     = SUM_W + SQ_W;
    localparam int COST_W    = 48;
    localparam int BND_W     = LOG_N;
    localparam int TAB_W     = COST_W + BND_W;
    localparam int ROW       = MAX_SAMPLES + 1;
    localparam int TAB_DEPTH = MAX_SEGMENTS * ROW;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam int KW        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int KMW       = $clog2(MAX_SEGMENTS + 1);
    localparam int DIV_W     = 2 * ABS_W + FRAC_BITS;
    localparam int DRAIN_CYC = DIV_W + 8;
    localparam int DRW       = $clog2(DRAIN_CYC + 1);

    // channel words
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          final_sample;
    } smp_t;

    typedef struct packed {
        logic [KMW-1:0]    segment_total;
        logic [KW-1:0]     endpoint_position;
        logic [CNT_W-1:0]  endpoint;
        logic [COST_W-1:0] partition_cost;
        logic              feasible;
        logic              last_of_run;
    } res_t;

    // one cell of the dynamic program in flight
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [CNT_W-1:0] s;
        logic [CNT_W-1:0] t;
        logic [KW-1:0]    k;
    } cell_tag_t;

    typedef struct packed {
        logic [SQ_W-1:0]   q;
        logic [COST_W-1:0] prev;
        cell_tag_t         tag;
    } div_side_t;

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [DIV_W-1:0] dq;
        logic [CNT_W-1:0] len;
        div_side_t        side;
    } div_stage_t;

    typedef struct packed {
        logic              we;
        logic [TAB_AW-1:0] addr;
        logic [TAB_W-1:0]  data;
        logic [CNT_W-1:0]  t;
        logic [KW-1:0]     k;
    } tab_wr_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_T_RD,
        ST_S_RUN,
        ST_DRAIN,
        ST_BT_RD,
        ST_BT_CAP,
        ST_EMIT,
        ST_INF
    } state_t;

    // row-major table address
    function automatic logic [TAB_AW-1:0] tab_addr(input logic [KW-1:0] k,
                                                   input logic [CNT_W-1:0] t);
        tab_addr = TAB_AW'(k) * TAB_AW'(ROW) + TAB_AW'(t);
    endfunction

endpackage

FILE: sv/sncp_ram.sv
module sncp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/sncp_div.sv
module sncp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [sncp_pkg::DIV_W-1:0]   dividend,
    input  logic [sncp_pkg::CNT_W-1:0]   divisor,
    input  sncp_pkg::div_side_t          side_in,
    output logic [sncp_pkg::DIV_W-1:0]   quotient,
    output sncp_pkg::div_side_t          side_out
);

    sncp_pkg::div_stage_t stage_in;
    sncp_pkg::div_stage_t stage_reg [sncp_pkg::DIV_W];

    // remainder starts at zero, dividend shifts out as quotient shifts in
    always_comb
    begin
        stage_in.rem  = '0;
        stage_in.dq   = dividend;
        stage_in.len  = divisor;
        stage_in.side = side_in;
    end

    // one restoring step per stage
    for (genvar i = 0; i < sncp_pkg::DIV_W; i++) begin : g_stage
        sncp_pkg::div_stage_t src;
        sncp_pkg::div_stage_t stage_next;
        logic [sncp_pkg::CNT_W:0] trial;

        if (i == 0) begin : g_first
            assign src = stage_in;
        end else begin : g_rest
            assign src = stage_reg[i-1];
        end

        always_comb
        begin
            trial      = {src.rem, src.dq[sncp_pkg::DIV_W-1]};
            stage_next = src;
            stage_next.dq = {src.dq[sncp_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, src.len})
            begin
                stage_next.rem   = sncp_pkg::CNT_W'(trial - {1'b0, src.len});
                stage_next.dq[0] = 1'b1;
            end
            else
            begin
                stage_next.rem = trial[sncp_pkg::CNT_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_reg[i] <= '0;
            end
            else
            begin
                stage_reg[i] <= stage_next;
            end
        end
    end

    assign quotient = stage_reg[sncp_pkg::DIV_W-1].dq;
    assign side_out = stage_reg[sncp_pkg::DIV_W-1].side;

endmodule

FILE: sv/sncp_cell.sv
module sncp_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sncp_pkg::cell_tag_t                issue,
    input  logic [sncp_pkg::PRE_W-1:0]         pre_rdata,
    input  logic [sncp_pkg::TAB_W-1:0]         tab_rdata,
    input  logic signed [sncp_pkg::SUM_W-1:0]  sum_t,
    input  logic [sncp_pkg::SQ_W-1:0]          sq_t,
    output sncp_pkg::tab_wr_t                  wr
);

    sncp_pkg::cell_tag_t p1_reg;
    sncp_pkg::cell_tag_t p2_tag_reg;
    sncp_pkg::cell_tag_t p3_tag_reg;
    sncp_pkg::cell_tag_t p5_tag_reg;

    logic signed [sncp_pkg::SUM_W-1:0] sum_s;
    logic [sncp_pkg::SQ_W-1:0]         sq_s;
    logic signed [sncp_pkg::SUM_W-1:0] diff;
    logic [sncp_pkg::ABS_W-1:0]        ad;
    logic [sncp_pkg::COST_W-1:0]       prev;

    logic [sncp_pkg::ABS_W-1:0]   ad_reg;
    logic [sncp_pkg::SQ_W-1:0]    q2_reg;
    logic [sncp_pkg::CNT_W-1:0]   len2_reg;
    logic [sncp_pkg::COST_W-1:0]  prev2_reg;

    logic [2*sncp_pkg::ABS_W-1:0] sqr_reg;
    logic [sncp_pkg::SQ_W-1:0]    q3_reg;
    logic [sncp_pkg::CNT_W-1:0]   len3_reg;
    logic [sncp_pkg::COST_W-1:0]  prev3_reg;

    sncp_pkg::div_side_t          div_side_in;
    sncp_pkg::div_side_t          div_side_out;
    logic [sncp_pkg::DIV_W-1:0]   quot;
    logic [sncp_pkg::DIV_W-1:0]   seg;

    logic [sncp_pkg::COST_W-1:0]  cand_reg;
    logic [sncp_pkg::COST_W-1:0]  best_reg;
    logic [sncp_pkg::COST_W-1:0]  best_next;
    logic [sncp_pkg::CNT_W-1:0]   arg_reg;
    logic [sncp_pkg::CNT_W-1:0]   arg_next;
    logic                         take;

    // memory data lines up with the issued cell once the cell is registered here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
        end
        else
        begin
            p1_reg <= issue;
        end
    end

    // segment sums, entry zero of the prefix arrays reads as zero
    always_comb
    begin
        sum_s = (p1_reg.s == '0) ? '0
              : $signed(pre_rdata[sncp_pkg::PRE_W-1 -: sncp_pkg::SUM_W]);
        sq_s  = (p1_reg.s == '0) ? '0 : pre_rdata[sncp_pkg::SQ_W-1:0];
        diff  = sum_t - sum_s;
        ad    = diff[sncp_pkg::SUM_W-1] ? sncp_pkg::ABS_W'(-diff)
                                        : sncp_pkg::ABS_W'(diff);
        prev  = (p1_reg.k == '0) ? '0
              : tab_rdata[sncp_pkg::TAB_W-1 -: sncp_pkg::COST_W];
    end

    // stage 2 and stage 3 (square)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_tag_reg <= '0;
            p3_tag_reg <= '0;
        end
        else
        begin
            p2_tag_reg <= p1_reg;
            p3_tag_reg <= p2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ad_reg    <= ad;
        q2_reg    <= sq_t - sq_s;
        len2_reg  <= p1_reg.t - p1_reg.s;
        prev2_reg <= prev;
        sqr_reg   <= ad_reg * ad_reg;
        q3_reg    <= q2_reg;
        len3_reg  <= len2_reg;
        prev3_reg <= prev2_reg;
    end

    // floor of scaled squared sum over the length
    always_comb
    begin
        div_side_in.q    = q3_reg;
        div_side_in.prev = prev3_reg;
        div_side_in.tag  = p3_tag_reg;
    end

    sncp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .dividend (sncp_pkg::DIV_W'(sqr_reg) << sncp_pkg::FRAC_BITS),
        .divisor  (len3_reg),
        .side_in  (div_side_in),
        .quotient (quot),
        .side_out (div_side_out)
    );

    assign seg = (sncp_pkg::DIV_W'(div_side_out.q) << sncp_pkg::FRAC_BITS) - quot;

    // candidate cost
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_tag_reg <= '0;
        end
        else
        begin
            p5_tag_reg <= div_side_out.tag;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= div_side_out.prev + sncp_pkg::COST_W'(seg);
    end

    // running minimum, earliest boundary kept on ties
    always_comb
    begin
        take      = p5_tag_reg.first || (cand_reg < best_reg);
        best_next = take ? cand_reg : best_reg;
        arg_next  = take ? p5_tag_reg.s : arg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p5_tag_reg.valid)
        begin
            best_reg <= best_next;
            arg_reg  <= arg_next;
        end
    end

    // table write on the last boundary of a cell
    always_comb
    begin
        wr.we   = p5_tag_reg.valid && p5_tag_reg.last;
        wr.addr = sncp_pkg::tab_addr(p5_tag_reg.k, p5_tag_reg.t);
        wr.data = {best_next, sncp_pkg::BND_W'(arg_next)};
        wr.t    = p5_tag_reg.t;
        wr.k    = p5_tag_reg.k;
    end

endmodule

FILE: sv/segment_neighborhood_changepoints.sv
// channel  | direction | word
// ---------+-----------+-------------------------------------------
// smp      | in        | sample, final_sample
// res      | out       | k, endpoint position, endpoint, cost, flags
// cfg      | in        | max_segments, always ready
//
// samples load while in the load state; the last one starts the dynamic program.
// each pass steps through the ends t, with one read state per end and then
// one boundary per cycle through the cost pipeline, and a drain after the
// pass; the backtrack then takes a read and a capture state per boundary,
// and then the result words go out. no sample is taken during a run.
// no clearing pass after reset; res stalls hold the emitter.

`include "assert_macros.svh"

module segment_neighborhood_changepoints (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           smp_valid,
    output logic           smp_ready,
    input  sncp_pkg::smp_t smp_data,
    output logic           res_valid,
    input  logic           res_ready,
    output sncp_pkg::res_t res_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [3:0]     cfg_data
);

    sncp_pkg::state_t state_reg;
    sncp_pkg::state_t state_next;

    logic [3:0]                          cfg_reg;
    logic [sncp_pkg::CNT_W-1:0]          cnt_reg;
    logic signed [sncp_pkg::SUM_W-1:0]   sum_reg;
    logic [sncp_pkg::SQ_W-1:0]           sq_reg;
    logic [sncp_pkg::CNT_W-1:0]          n_reg;
    logic [sncp_pkg::KMW-1:0]            kmax_reg;
    logic [sncp_pkg::KW-1:0]             k_reg;
    logic [sncp_pkg::CNT_W-1:0]          t_reg;
    logic [sncp_pkg::CNT_W-1:0]          s_reg;
    logic                                tcap_reg;
    logic signed [sncp_pkg::SUM_W-1:0]   sum_t_reg;
    logic [sncp_pkg::SQ_W-1:0]           sq_t_reg;
    logic [sncp_pkg::DRW-1:0]            drain_reg;
    logic [sncp_pkg::KW-1:0]             bk_reg;
    logic [sncp_pkg::KW-1:0]             cur_reg;
    logic [sncp_pkg::CNT_W-1:0]          tt_reg;
    logic [sncp_pkg::KW-1:0]             pos_reg;
    logic [sncp_pkg::CNT_W-1:0]          cp_reg [sncp_pkg::MAX_SEGMENTS];
    logic [sncp_pkg::COST_W-1:0]         cost_reg;
    sncp_pkg::res_t                      res_reg;
    logic                                res_valid_reg;

    logic                                smp_fire;
    logic                                room;
    logic [sncp_pkg::SAMPLE_BITS-1:0]    sample_abs;
    logic [2*sncp_pkg::SAMPLE_BITS-1:0]  sample_sq;
    logic signed [sncp_pkg::SUM_W-1:0]   sum_new;
    logic [sncp_pkg::SQ_W-1:0]           sq_new;
    logic [sncp_pkg::KMW-1:0]            kmax_eff;
    logic [sncp_pkg::CNT_W-1:0]          n_final;

    logic                                last_s;
    logic                                drain_done;
    logic                                pass_more;
    logic                                k_done_last;
    logic                                next_infeas;
    logic                                slot_free;
    logic                                out_load;
    sncp_pkg::res_t                      out_item;
    sncp_pkg::cell_tag_t                 issue;
    logic [sncp_pkg::CNT_W-1:0]          pre_raddr;
    logic [sncp_pkg::TAB_AW-1:0]         tab_raddr;
    logic [sncp_pkg::PRE_W-1:0]          pre_rdata;
    logic [sncp_pkg::TAB_W-1:0]          tab_rdata;
    sncp_pkg::tab_wr_t                   tab_wr;

    // loader arithmetic
    always_comb
    begin
        smp_fire   = smp_valid && smp_ready;
        room       = cnt_reg < sncp_pkg::CNT_W'(sncp_pkg::MAX_SAMPLES);
        sample_abs = smp_data.sample[sncp_pkg::SAMPLE_BITS-1]
                   ? sncp_pkg::SAMPLE_BITS'(-smp_data.sample)
                   : sncp_pkg::SAMPLE_BITS'(smp_data.sample);
        sample_sq  = sample_abs * sample_abs;
        sum_new    = sum_reg + sncp_pkg::SUM_W'(smp_data.sample);
        sq_new     = sq_reg + sncp_pkg::SQ_W'(sample_sq);
        n_final    = room ? cnt_reg + sncp_pkg::CNT_W'(1) : cnt_reg;
        if (cfg_reg == '0)
        begin
            kmax_eff = sncp_pkg::KMW'(1);
        end
        else if (int'(cfg_reg) > sncp_pkg::MAX_SEGMENTS)
        begin
            kmax_eff = sncp_pkg::KMW'(sncp_pkg::MAX_SEGMENTS);
        end
        else
        begin
            kmax_eff = sncp_pkg::KMW'(cfg_reg);
        end
    end

    // sequencing conditions
    always_comb
    begin
        last_s      = (k_reg == '0) || (s_reg == t_reg - sncp_pkg::CNT_W'(1));
        drain_done  = drain_reg == sncp_pkg::DRW'(sncp_pkg::DRAIN_CYC - 1);
        pass_more   = (sncp_pkg::CNT_W'(k_reg) + sncp_pkg::CNT_W'(1)
                          < sncp_pkg::CNT_W'(kmax_reg))
                   && (sncp_pkg::CNT_W'(k_reg) + sncp_pkg::CNT_W'(1) < n_reg);
        k_done_last = sncp_pkg::KMW'(bk_reg) + sncp_pkg::KMW'(1) == kmax_reg;
        next_infeas = sncp_pkg::CNT_W'(bk_reg) + sncp_pkg::CNT_W'(2) > n_reg;
        slot_free   = !res_valid_reg || res_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sncp_pkg::ST_LOAD:
            begin
                if (smp_fire && smp_data.final_sample)
                begin
                    state_next = sncp_pkg::ST_T_RD;
                end
            end
            sncp_pkg::ST_T_RD:
            begin
                state_next = sncp_pkg::ST_S_RUN;
            end
            sncp_pkg::ST_S_RUN:
            begin
                if (last_s)
                begin
                    state_next = (t_reg == n_reg) ? sncp_pkg::ST_DRAIN
                                                  : sncp_pkg::ST_T_RD;
                end
            end
            sncp_pkg::ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = pass_more ? sncp_pkg::ST_T_RD : sncp_pkg::ST_BT_RD;
                end
            end
            sncp_pkg::ST_BT_RD:
            begin
                state_next = sncp_pkg::ST_BT_CAP;
            end
            sncp_pkg::ST_BT_CAP:
            begin
                if (cur_reg == sncp_pkg::KW'(0) || cur_reg == sncp_pkg::KW'(1))
                begin
                    state_next = sncp_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = sncp_pkg::ST_BT_RD;
                end
            end
            sncp_pkg::ST_EMIT, sncp_pkg::ST_INF:
            begin
                if (slot_free && (state_reg == sncp_pkg::ST_INF || pos_reg == bk_reg))
                begin
                    if (k_done_last)
                    begin
                        state_next = sncp_pkg::ST_LOAD;
                    end
                    else if (next_infeas)
                    begin
                        state_next = sncp_pkg::ST_INF;
                    end
                    else
                    begin
                        state_next = sncp_pkg::ST_BT_RD;
                    end
                end
            end
            default:
            begin
                state_next = sncp_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        issue       = '0;
        pre_raddr   = s_reg;
        tab_raddr   = sncp_pkg::tab_addr(sncp_pkg::KW'(k_reg - sncp_pkg::KW'(1)), s_reg);
        out_load    = 1'b0;
        out_item    = '0;
        unique case (state_reg)
            sncp_pkg::ST_T_RD:
            begin
                pre_raddr = t_reg;
            end
            sncp_pkg::ST_S_RUN:
            begin
                issue.valid = 1'b1;
                issue.first = s_reg == sncp_pkg::CNT_W'(k_reg);
                issue.last  = last_s;
                issue.s     = s_reg;
                issue.t     = t_reg;
                issue.k     = k_reg;
            end
            sncp_pkg::ST_BT_RD:
            begin
                tab_raddr = sncp_pkg::tab_addr(cur_reg, tt_reg);
            end
            sncp_pkg::ST_EMIT:
            begin
                out_load                   = slot_free;
                out_item.segment_total     = sncp_pkg::KMW'(bk_reg) + sncp_pkg::KMW'(1);
                out_item.endpoint_position = pos_reg;
                out_item.endpoint          = cp_reg[pos_reg];
                out_item.partition_cost    = cost_reg;
                out_item.feasible          = 1'b1;
                out_item.last_of_run       = (pos_reg == bk_reg) && k_done_last;
            end
            sncp_pkg::ST_INF:
            begin
                out_load                   = slot_free;
                out_item.segment_total     = sncp_pkg::KMW'(bk_reg) + sncp_pkg::KMW'(1);
                out_item.partition_cost    = '1;
                out_item.last_of_run       = k_done_last;
            end
            default:
            begin
                issue = '0;
            end
        endcase
    end

    // state and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sncp_pkg::ST_LOAD;
            cfg_reg   <= 4'd1;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            n_reg     <= '0;
            kmax_reg  <= '0;
            k_reg     <= '0;
            t_reg     <= '0;
            s_reg     <= '0;
            tcap_reg  <= 1'b0;
            drain_reg <= '0;
            bk_reg    <= '0;
            cur_reg   <= '0;
            tt_reg    <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tcap_reg  <= state_reg == sncp_pkg::ST_T_RD;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
            case (state_reg)
                sncp_pkg::ST_LOAD:
                begin
                    if (smp_fire && smp_data.final_sample)
                    begin
                        n_reg    <= n_final;
                        kmax_reg <= kmax_eff;
                        cnt_reg  <= '0;
                        sum_reg  <= '0;
                        sq_reg   <= '0;
                        k_reg    <= '0;
                        t_reg    <= sncp_pkg::CNT_W'(1);
                    end
                    else if (smp_fire && room)
                    begin
                        cnt_reg <= cnt_reg + sncp_pkg::CNT_W'(1);
                        sum_reg <= sum_new;
                        sq_reg  <= sq_new;
                    end
                end
                sncp_pkg::ST_T_RD:
                begin
                    s_reg <= sncp_pkg::CNT_W'(k_reg);
                end
                sncp_pkg::ST_S_RUN:
                begin
                    if (last_s)
                    begin
                        drain_reg <= '0;
                        if (t_reg != n_reg)
                        begin
                            t_reg <= t_reg + sncp_pkg::CNT_W'(1);
                        end
                    end
                    else
                    begin
                        s_reg <= s_reg + sncp_pkg::CNT_W'(1);
                    end
                end
                sncp_pkg::ST_DRAIN:
                begin
                    drain_reg <= drain_reg + sncp_pkg::DRW'(1);
                    if (drain_done)
                    begin
                        if (pass_more)
                        begin
                            k_reg <= k_reg + sncp_pkg::KW'(1);
                            t_reg <= sncp_pkg::CNT_W'(k_reg) + sncp_pkg::CNT_W'(2);
                        end
                        else
                        begin
                            bk_reg  <= '0;
                            cur_reg <= '0;
                            tt_reg  <= n_reg;
                            pos_reg <= '0;
                        end
                    end
                end
                sncp_pkg::ST_BT_CAP:
                begin
                    pos_reg <= '0;
                    if (cur_reg != '0)
                    begin
                        tt_reg  <= sncp_pkg::CNT_W'(tab_rdata[sncp_pkg::BND_W-1:0]);
                        cur_reg <= cur_reg - sncp_pkg::KW'(1);
                    end
                end
                sncp_pkg::ST_EMIT, sncp_pkg::ST_INF:
                begin
                    if (slot_free)
                    begin
                        if (state_reg == sncp_pkg::ST_EMIT && pos_reg != bk_reg)
                        begin
                            pos_reg <= pos_reg + sncp_pkg::KW'(1);
                        end
                        else if (!k_done_last)
                        begin
                            bk_reg  <= bk_reg + sncp_pkg::KW'(1);
                            cur_reg <= bk_reg + sncp_pkg::KW'(1);
                            tt_reg  <= n_reg;
                            pos_reg <= '0;
                        end
                    end
                end
                default:
                begin
                    pos_reg <= pos_reg;
                end
            endcase
        end
    end

    // end-point prefix capture and backtrack payload
    always_ff @(posedge clk)
    begin
        if (tcap_reg)
        begin
            sum_t_reg <= $signed(pre_rdata[sncp_pkg::PRE_W-1 -: sncp_pkg::SUM_W]);
            sq_t_reg  <= pre_rdata[sncp_pkg::SQ_W-1:0];
        end
        if (state_reg == sncp_pkg::ST_DRAIN && drain_done && !pass_more)
        begin
            cp_reg[0] <= n_reg;
        end
        if (state_reg == sncp_pkg::ST_BT_CAP)
        begin
            if (cur_reg == bk_reg)
            begin
                cost_reg <= tab_rdata[sncp_pkg::TAB_W-1 -: sncp_pkg::COST_W];
            end
            if (cur_reg != '0)
            begin
                cp_reg[sncp_pkg::KW'(cur_reg - sncp_pkg::KW'(1))]
                    <= sncp_pkg::CNT_W'(tab_rdata[sncp_pkg::BND_W-1:0]);
            end
        end
        if ((state_reg == sncp_pkg::ST_EMIT || state_reg == sncp_pkg::ST_INF) && slot_free
            && (state_reg == sncp_pkg::ST_INF || pos_reg == bk_reg) && !k_done_last)
        begin
            cp_reg[sncp_pkg::KW'(bk_reg + sncp_pkg::KW'(1))] <= n_reg;
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg <= out_item;
        end
    end

    // prefix sums of values and squares
    sncp_ram #(
        .WIDTH (sncp_pkg::PRE_W),
        .DEPTH (sncp_pkg::ROW)
    ) u_pre_ram (
        .clk   (clk),
        .we    (smp_fire && room),
        .waddr (cnt_reg + sncp_pkg::CNT_W'(1)),
        .wdata ({sum_new, sq_new}),
        .raddr (pre_raddr),
        .rdata (pre_rdata)
    );

    // best cost and boundary per segment count and end
    sncp_ram #(
        .WIDTH (sncp_pkg::TAB_W),
        .DEPTH (sncp_pkg::TAB_DEPTH)
    ) u_tab_ram (
        .clk   (clk),
        .we    (tab_wr.we),
        .waddr (tab_wr.addr),
        .wdata (tab_wr.data),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    sncp_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .pre_rdata (pre_rdata),
        .tab_rdata (tab_rdata),
        .sum_t     (sum_t_reg),
        .sq_t      (sq_t_reg),
        .wr        (tab_wr)
    );

    assign smp_ready = state_reg == sncp_pkg::ST_LOAD;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // checks
    `SNCP_ASSERT_IMP(a_feasible_endpoint, clk, rst_n,
        res_valid_reg && res_reg.feasible, res_reg.endpoint != '0)
    `SNCP_ASSERT_IMP(a_write_only_in_passes, clk, rst_n, tab_wr.we,
        state_reg == sncp_pkg::ST_S_RUN || state_reg == sncp_pkg::ST_T_RD
        || state_reg == sncp_pkg::ST_DRAIN)
    `SNCP_ASSERT_IMP(a_boundary_before_end, clk, rst_n,
        state_reg == sncp_pkg::ST_S_RUN, s_reg < t_reg)
    `SNCP_ASSERT_NEXT(a_run_starts_clean, clk, rst_n,
        smp_fire && smp_data.final_sample, cnt_reg == '0 && n_reg != '0)

endmodule

FILE: tb/sncp_checker.sv
module sncp_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           smp_valid,
    input  logic           smp_ready,
    input  sncp_pkg::smp_t smp_data,
    input  logic           res_valid,
    input  logic           res_ready,
    input  sncp_pkg::res_t res_data,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [3:0]     cfg_data,
    output int             errors,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] INF_COST = '1;

    logic [3:0]     seg_limit;
    int             loaded;
    longint         run_sum [0:sncp_pkg::MAX_SAMPLES];
    longint         run_sq [0:sncp_pkg::MAX_SAMPLES];
    logic [47:0]    opt_cost [0:sncp_pkg::MAX_SEGMENTS-1][0:sncp_pkg::MAX_SAMPLES];
    int             opt_cut [0:sncp_pkg::MAX_SEGMENTS-1][0:sncp_pkg::MAX_SAMPLES];
    sncp_pkg::res_t words_due[$];

    // fixed-point squared error of samples s+1..t
    function automatic logic [47:0] span_error(int s, int t);
        longint d;
        longint q;
        logic [63:0] ad;
        logic [63:0] sq;
        d = run_sum[t] - run_sum[s];
        q = run_sq[t] - run_sq[s];
        ad = (d < 0) ? -d : d;
        sq = (ad * ad) << sncp_pkg::FRAC_BITS;
        return 48'((64'(q) << sncp_pkg::FRAC_BITS) - sq / 64'(t - s));
    endfunction

    // dynamic program over all loaded samples, then backtrack
    task automatic solve_partitions();
        int n;
        int kmax;
        int cur;
        int tt;
        int ends [0:sncp_pkg::MAX_SEGMENTS-1];
        logic [47:0] best;
        logic [47:0] c;
        sncp_pkg::res_t w;
        n = loaded;
        kmax = (seg_limit == 0) ? 1
             : (seg_limit > sncp_pkg::MAX_SEGMENTS ? sncp_pkg::MAX_SEGMENTS : seg_limit);
        for (int t = 1; t <= n; t++)
        begin
            opt_cost[0][t] = span_error(0, t);
            opt_cut[0][t] = 0;
        end
        for (int k = 1; k < kmax; k++)
            for (int t = k + 1; t <= n; t++)
            begin
                best = '0;
                opt_cut[k][t] = k;
                for (int s = k; s < t; s++)
                begin
                    c = opt_cost[k-1][s] + span_error(s, t);
                    if (s == k || c < best)
                    begin
                        best = c;
                        opt_cut[k][t] = s;
                    end
                end
                opt_cost[k][t] = best;
            end
        for (int k = 0; k < kmax; k++)
        begin
            w = '0;
            w.segment_total = 4'(k + 1);
            if (k + 1 > n)
            begin
                w.partition_cost = INF_COST;
                words_due.push_back(w);
            end
            else
            begin
                ends[k] = n;
                cur = k;
                tt = n;
                for (int i = k; i > 0; i--)
                begin
                    ends[i-1] = opt_cut[cur][tt];
                    tt = ends[i-1];
                    cur--;
                end
                for (int i = 0; i <= k; i++)
                begin
                    w.endpoint_position = 3'(i);
                    w.endpoint = 9'(ends[i]);
                    w.partition_cost = opt_cost[k][n];
                    w.feasible = 1'b1;
                    words_due.push_back(w);
                end
            end
        end
        w = words_due.pop_back();
        w.last_of_run = 1'b1;
        words_due.push_back(w);
        loaded = 0;
    endtask

    // watch all channels
    always @(posedge clk or negedge rst_n)
    begin
        sncp_pkg::res_t want;
        longint v;
        if (!rst_n)
        begin
            seg_limit = 4'd1;
            loaded = 0;
            run_sum[0] = 0;
            run_sq[0] = 0;
            words_due.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                seg_limit = cfg_data;
            if (smp_valid && smp_ready)
            begin
                if (loaded < sncp_pkg::MAX_SAMPLES)
                begin
                    v = smp_data.sample;
                    run_sum[loaded+1] = run_sum[loaded] + v;
                    run_sq[loaded+1] = run_sq[loaded] + v * v;
                    loaded++;
                end
                if (smp_data.final_sample)
                    solve_partitions();
            end
            if (res_valid && res_ready)
            begin
                if (words_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word %p", res_data);
                end
                else
                begin
                    want = words_due.pop_front();
                    if (want !== res_data)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp %p got %p", want, res_data);
                    end
                end
            end
            pending = words_due.size();
        end
    end
endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic           clk;
    logic           rst_n;
    logic           smp_valid;
    logic           smp_ready;
    sncp_pkg::smp_t smp_data;
    logic           res_valid;
    logic           res_ready;
    sncp_pkg::res_t res_data;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [3:0]     cfg_data;
    int             errors;
    int             pending;
    int             idle_cycles;
    int             stall_mode;

    localparam int WATCHDOG = 1000000;

    segment_neighborhood_changepoints dut (
        .clk(clk), .rst_n(rst_n),
        .smp_valid(smp_valid), .smp_ready(smp_ready), .smp_data(smp_data),
        .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    sncp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .smp_valid(smp_valid), .smp_ready(smp_ready), .smp_data(smp_data),
        .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern, changing mode now and then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= ($urandom_range(0, 3) != 0);
                2: res_ready <= ($urandom_range(0, 3) == 0);
                default: res_ready <= ~res_ready;
            endcase
        end
    end

    // watchdog on handshakes
    always @(posedge clk)
    begin
        if (!rst_n || (smp_valid && smp_ready) || (res_valid && res_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic send_word(logic signed [15:0] v, logic fin);
        smp_valid <= 1'b1;
        smp_data <= '{sample: v, final_sample: fin};
        @(posedge clk);
        while (!smp_ready)
            @(posedge clk);
    endtask

    // burst gap: drop valid for a random stretch
    task automatic maybe_gap();
        int g;
        if ($urandom_range(0, 3) == 0)
        begin
            g = $urandom_range(1, 6);
            smp_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        smp_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_limit(logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_value(int style);
        case (style)
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    // a series of len samples with a few level shifts
    task automatic send_series(int len, int style);
        logic signed [15:0] base;
        base = pick_value(style);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                base = pick_value(style);
            send_word(16'(base + (style == 3 ? $signed($urandom_range(0, 8)) : 0)),
                      i == len - 1);
            maybe_gap();
        end
    endtask

    initial
    begin
        int n;
        bit drained;
        rst_n = 1'b0;
        smp_valid = 1'b0;
        smp_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset limit, one sample, extremes, infeasible counts
        send_word(16'sh7fff, 1'b1);
        drain_results();
        write_limit(4'd8);
        send_word(-16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sh0000, 1'b1);
        drain_results();
        write_limit(4'd0);
        send_series(4, 2);
        drain_results();
        write_limit(4'd15);
        send_word(16'sh0005, 1'b0);
        send_word(16'sh0005, 1'b0);
        send_word(-16'sh0001, 1'b0);
        send_word(-16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b1);
        drain_results();
        // capacity overflow, largest segment count
        write_limit(4'd8);
        for (int i = 0; i < sncp_pkg::MAX_SAMPLES + 1; i++)
            send_word(16'($urandom_range(0, 65535)), i == sncp_pkg::MAX_SAMPLES);
        drain_results();

        // random series, mostly short; the limit changes only when idle
        n = 0;
        drained = 1'b1;
        while (n < 40)
        begin
            int len;
            if (drained)
                write_limit(4'($urandom_range(0, 15)));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
            send_series(len, $urandom_range(0, 3));
            n += len;
            if ($urandom_range(0, 2) == 0)
            begin
                drain_results();
                drained = 1'b1;
            end
            else
            begin
                smp_valid <= 1'b0;
                drained = 1'b0;
            end
        end
        drain_results();
        repeat (100) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
